// ----- hdl/swqt_pkg.sv -----
// ----------------------------------------------------------------------------
// swqt_pkg
// Shared codes, defaults and types for the semaphore wait-queue table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swqt_pkg;

    localparam int MAX_PROCS_DEF = 20;
    localparam int KEY_BITS_DEF  = 32;

    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int PROC_W = 5;
    localparam int SKEY_W = 32;

    localparam logic [CMD_W-1:0] CMD_BLOCK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNFIRST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPROC  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    // classification of one queued item
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             inv;   // null key or process out of range
    } t_cls;

endpackage

`default_nettype wire

// ----- hdl/swqt_front.sv -----
// ----------------------------------------------------------------------------
// swqt_front
// Accepts items, flags malformed requests and holds them in a 2-deep queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swqt_front #(
    parameter int MAX_PROCS = 20,
    parameter int KEY_BITS  = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [swqt_pkg::CMD_W-1:0]   i_command,
    input  wire logic [swqt_pkg::SKEY_W-1:0]  i_sem_key,
    input  wire logic [swqt_pkg::PROC_W-1:0]  i_proc_id,
    output logic                              o_q_valid,
    input  wire logic                         i_q_pop,
    output swqt_pkg::t_cls                    o_q_cls,
    output logic [KEY_BITS-1:0]               o_q_key,
    output logic [swqt_pkg::PROC_W-1:0]       o_q_pid
);
    import swqt_pkg::*;

    logic [SKEY_W+63:0] w_key_ext;
    logic [KEY_BITS-1:0] w_key;
    logic               w_pid_bad;
    t_cls               w_cls;
    logic               w_push;

    t_cls               r_q_cls [2];
    logic [KEY_BITS-1:0] r_q_key [2];
    logic [PROC_W-1:0]  r_q_pid [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;

    assign w_key_ext = {64'b0, i_sem_key};
    assign w_key     = w_key_ext[KEY_BITS-1:0];
    assign w_pid_bad = {2'b0, i_proc_id} >= 7'(MAX_PROCS);

    always_comb begin
        w_cls.cmd = i_command;
        unique case (i_command)
            CMD_BLOCK:  w_cls.inv = (w_key == '0) || w_pid_bad;
            CMD_UNPROC: w_cls.inv = w_pid_bad;
            default:    w_cls.inv = (w_key == '0);
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cls   = r_q_cls[r_rp];
    assign o_q_key   = r_q_key[r_rp];
    assign o_q_pid   = r_q_pid[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q_cls[r_wp] <= w_cls;
                r_q_key[r_wp] <= w_key;
                r_q_pid[r_wp] <= i_proc_id;
                r_wp          <= ~r_wp;
            end
            if (i_q_pop && o_q_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop && o_q_valid);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/swqt_back.sv -----
// ----------------------------------------------------------------------------
// swqt_back
// Sequencer over the descriptor table and the per-process link store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swqt_back #(
    parameter int MAX_PROCS = 20,
    parameter int KEY_BITS  = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    output logic                              o_q_pop,
    input  wire swqt_pkg::t_cls               i_q_cls,
    input  wire logic [KEY_BITS-1:0]          i_q_key,
    input  wire logic [swqt_pkg::PROC_W-1:0]  i_q_pid,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [swqt_pkg::STAT_W-1:0]       o_status,
    output logic [swqt_pkg::PROC_W-1:0]       o_result_proc,
    output logic                              o_result_valid
);
    import swqt_pkg::*;

    localparam int PW = $clog2(MAX_PROCS);
    localparam int SW = $clog2(MAX_PROCS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_APPEND = 4'd2;
    localparam logic [3:0] S_LINK0  = 4'd3;
    localparam logic [3:0] S_POP    = 4'd4;
    localparam logic [3:0] S_POP2   = 4'd5;
    localparam logic [3:0] S_PEEKH  = 4'd6;
    localparam logic [3:0] S_RMV    = 4'd7;
    localparam logic [3:0] S_WALK   = 4'd8;
    localparam logic [3:0] S_CHK    = 4'd9;
    localparam logic [3:0] S_UNLINK = 4'd10;

    logic [3:0]          r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [PW-1:0]       r_pid, r_d, r_free, r_idx, r_cur, r_prev;
    logic                r_free_ok;
    logic [SW-1:0]       r_steps;

    logic [MAX_PROCS-1:0] r_busy, r_blk;
    logic [KEY_BITS-1:0]  r_dkey [MAX_PROCS];
    logic [PW-1:0]        r_head [MAX_PROCS];
    logic [PW-1:0]        r_tail [MAX_PROCS];
    logic [PW-1:0]        r_link [MAX_PROCS];
    logic [PW-1:0]        r_dix  [MAX_PROCS];

    logic                r_o_valid, r_o_rv;
    logic [STAT_W-1:0]   r_o_status;
    logic [PROC_W-1:0]   r_o_proc;

    logic [PW-1:0] w_qpid, w_fd;
    logic          w_take, w_match, w_fo;

    assign w_qpid  = PW'(i_q_pid);
    assign w_take  = (r_state == S_IDLE) && i_q_valid && !r_o_valid;
    assign o_q_pop = w_take;
    assign w_match = r_busy[r_idx] && (r_dkey[r_idx] == r_key);
    assign w_fo    = r_free_ok || !r_busy[r_idx];
    assign w_fd    = r_free_ok ? r_free : r_idx;

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_proc  = r_o_proc;
    assign o_result_valid = r_o_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_busy    <= '0;
            r_blk     <= '0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_cmd     <= i_q_cls.cmd;
                        r_key     <= i_q_key;
                        r_pid     <= w_qpid;
                        r_idx     <= '0;
                        r_free_ok <= 1'b0;
                        if (i_q_cls.inv) begin
                            r_o_valid <= 1'b1; r_o_status <= ST_INVALID;
                            r_o_proc <= '0; r_o_rv <= 1'b0;
                        end else begin
                            unique case (i_q_cls.cmd)
                                CMD_BLOCK: begin
                                    if (r_blk[w_qpid]) begin
                                        r_o_valid <= 1'b1; r_o_status <= ST_INVALID;
                                        r_o_proc <= '0; r_o_rv <= 1'b0;
                                    end else begin
                                        r_state <= S_SCAN;
                                    end
                                end
                                CMD_UNPROC: begin
                                    if (!r_blk[w_qpid]) begin
                                        r_o_valid <= 1'b1; r_o_status <= ST_NOTFOUND;
                                        r_o_proc <= '0; r_o_rv <= 1'b0;
                                    end else begin
                                        r_d     <= r_dix[w_qpid];
                                        r_state <= S_RMV;
                                    end
                                end
                                default: r_state <= S_SCAN;
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    if (w_match) begin
                        r_d <= r_idx;
                        unique case (r_cmd)
                            CMD_BLOCK:   r_state <= S_APPEND;
                            CMD_UNFIRST: r_state <= S_POP;
                            default:     r_state <= S_PEEKH;
                        endcase
                    end else if (r_idx == PW'(MAX_PROCS - 1)) begin
                        if (r_cmd == CMD_BLOCK && w_fo) begin
                            r_busy[w_fd] <= 1'b1;
                            r_dkey[w_fd] <= r_key;
                            r_head[w_fd] <= r_pid;
                            r_tail[w_fd] <= r_pid;
                            r_blk[r_pid] <= 1'b1;
                            r_dix[r_pid] <= w_fd;
                            r_state      <= S_LINK0;
                        end else begin
                            r_o_valid  <= 1'b1;
                            r_o_status <= (r_cmd == CMD_BLOCK) ? ST_FULL : ST_NOTFOUND;
                            r_o_proc   <= '0; r_o_rv <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        if (!r_busy[r_idx] && !r_free_ok) begin
                            r_free    <= r_idx;
                            r_free_ok <= 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_APPEND: begin
                    r_link[r_tail[r_d]] <= r_pid;
                    r_tail[r_d]         <= r_pid;
                    r_blk[r_pid]        <= 1'b1;
                    r_dix[r_pid]        <= r_d;
                    r_state             <= S_LINK0;
                end
                S_LINK0: begin
                    r_link[r_pid] <= '0;
                    r_o_valid <= 1'b1; r_o_status <= ST_OK;
                    r_o_proc <= '0; r_o_rv <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_POP: begin
                    r_cur   <= r_head[r_d];
                    r_state <= S_POP2;
                end
                S_POP2: begin
                    r_blk[r_cur] <= 1'b0;
                    if (r_tail[r_d] == r_cur) begin
                        r_busy[r_d] <= 1'b0;
                    end else begin
                        r_head[r_d] <= r_link[r_cur];
                    end
                    r_o_valid <= 1'b1; r_o_status <= ST_OK;
                    r_o_proc <= PROC_W'(r_cur); r_o_rv <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_PEEKH: begin
                    r_o_valid <= 1'b1; r_o_status <= ST_OK;
                    r_o_proc <= PROC_W'(r_head[r_d]); r_o_rv <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_RMV: begin
                    if (!r_busy[r_d]) begin
                        r_o_valid <= 1'b1; r_o_status <= ST_NOTFOUND;
                        r_o_proc <= '0; r_o_rv <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_head[r_d] == r_pid) begin
                        r_cur   <= r_pid;
                        r_state <= S_POP2;
                    end else begin
                        r_prev  <= r_head[r_d];
                        r_steps <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_steps == SW'(MAX_PROCS) || r_prev == r_tail[r_d]) begin
                        r_o_valid <= 1'b1; r_o_status <= ST_NOTFOUND;
                        r_o_proc <= '0; r_o_rv <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cur   <= r_link[r_prev];
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_cur == r_pid) begin
                        r_state <= S_UNLINK;
                    end else begin
                        r_prev  <= r_cur;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_WALK;
                    end
                end
                S_UNLINK: begin
                    r_link[r_prev] <= r_link[r_pid];
                    if (r_tail[r_d] == r_pid) begin
                        r_tail[r_d] <= r_prev;
                    end
                    r_blk[r_pid] <= 1'b0;
                    r_o_valid <= 1'b1; r_o_status <= ST_OK;
                    r_o_proc <= PROC_W'(r_pid); r_o_rv <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_rv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (!r_o_rv || r_o_status == ST_OK))
        else $error("result process without ok status");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_ready) |-> !o_q_pop)
        else $error("item taken while result pending");
    a_unlink_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNLINK) |=> !r_blk[$past(r_pid)])
        else $error("removed process still blocked");
    a_link_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK0) |=> (r_blk[$past(r_pid)] && r_o_valid))
        else $error("block did not complete");
`endif

endmodule

`default_nettype wire

// ----- hdl/semaphore_wait_queue_table.sv -----
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table
// Table of semaphore descriptors, each with a FIFO of blocked processes.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid/o_ready) carries one command item: block,
//  unblock first, unblock a given process, or peek at the head.
//  Output channel (o_valid/i_ready) returns exactly one result item per
//  command: status, process id and a flag saying the id is meaningful.
//  A front stage checks for a null key or an out-of-range process and
//  parks items in a two-deep queue; a back sequencer walks the table.
//  Malformed or double-block items are answered from the idle state.
//  Block, unblock-first and peek scan descriptors one per cycle.
//  Unblock-process walks the wait list link by link, through a walk
//  state and a check state for each link. The sequencer finishes one
//  item before it takes the next.
//  Reset clears the control state and the busy and blocked flags; other
//  stores are written before they are read. A stalled receiver holds the
//  result register, and the sequencer takes no new item until it drains;
//  the front queue keeps accepting until its two slots are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module semaphore_wait_queue_table #(
    parameter int MAX_PROCS = swqt_pkg::MAX_PROCS_DEF,
    parameter int KEY_BITS  = swqt_pkg::KEY_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [swqt_pkg::CMD_W-1:0]   i_command,
    input  wire logic [swqt_pkg::SKEY_W-1:0]  i_sem_key,
    input  wire logic [swqt_pkg::PROC_W-1:0]  i_proc_id,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [swqt_pkg::STAT_W-1:0]       o_status,
    output logic [swqt_pkg::PROC_W-1:0]       o_result_proc,
    output logic                              o_result_valid
);
    import swqt_pkg::*;

    // queue head between front and back
    logic                q_valid, q_pop;
    t_cls                q_cls;
    logic [KEY_BITS-1:0] q_key;
    logic [PROC_W-1:0]   q_pid;

    swqt_front #(.MAX_PROCS(MAX_PROCS), .KEY_BITS(KEY_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_sem_key(i_sem_key), .i_proc_id(i_proc_id),
        .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_cls(q_cls), .o_q_key(q_key), .o_q_pid(q_pid)
    );

    swqt_back #(.MAX_PROCS(MAX_PROCS), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_cls(q_cls), .i_q_key(q_key), .i_q_pid(q_pid),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_result_proc(o_result_proc),
        .o_result_valid(o_result_valid)
    );

endmodule

`default_nettype wire
